@@ sv/assert_macros.svh @@
// Assertion macros used by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ sv/issa_pkg.sv @@
// Types and codes of the slot allocator.
package issa_pkg;
	typedef enum logic [1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE  = 2'd1,
		ACT_ADD   = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_FREE    = 2'd1,
		ST_NO_AREA    = 2'd2,
		ST_TABLE_FULL = 2'd3
	} status_t;

	localparam logic CFG_MAX_CONTIG  = 1'b0;
	localparam logic CFG_SORTED_FREE = 1'b1;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	typedef struct packed {
		logic [1:0]  action;
		logic [11:0] slot;
		logic [10:0] area_slots;
		logic [10:0] skip_slots;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] granted_slot;
		logic [12:0] free_total;
		logic        hint_hit;
	} out_beat_t;
endpackage

@@ sv/interleaved_swap_slot_allocator.sv @@
// Multi-area slot allocator: top level with control sequencer.
// One beat in, one beat out. Free lists are chained through a single link
// memory (one write, one registered read per cycle). Allocate: S_ALLOC, again
// for each empty area passed over, then S_POP and S_FIN. Unsorted free or a
// rejected beat: straight to S_FIN. Sorted free: S_WALK, again for each list
// entry walked (from the hint when it lies below the slot), then S_INS when
// the slot is inserted, then S_FIN. Add area: S_ADD for each slot linked
// (area_slots - skip_slots after saturation), then S_FIN. The link memory
// needs no clearing pass after reset. A new beat is taken once the result of
// the previous one sits in the output register.
module interleaved_swap_slot_allocator #(
	parameter int NUM_AREAS = 4,
	parameter int SLOTS_PER_AREA = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  issa_pkg::in_beat_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output issa_pkg::out_beat_t            out_data,
	input  logic                           cfg_we,
	input  logic [issa_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [issa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import issa_pkg::*;
	`include "assert_macros.svh"

	localparam int TOTAL = NUM_AREAS * SLOTS_PER_AREA;
	localparam int SW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int LW = $clog2(TOTAL + 1);
	localparam int AW = (NUM_AREAS > 1) ? $clog2(NUM_AREAS) : 1;
	localparam int ACW = $clog2(NUM_AREAS + 1);
	localparam int NW = $clog2(SLOTS_PER_AREA + 1);
	localparam int XW = (NW > 12) ? NW : 12;
	localparam logic [LW-1:0] NIL = LW'(TOTAL);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_ALLOC = 7'b0000010,
		S_POP   = 7'b0000100,
		S_WALK  = 7'b0001000,
		S_INS   = 7'b0010000,
		S_ADD   = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	state_t state_q;
	logic [15:0] max_contig_q;
	logic sorted_free_q;
	logic [LW-1:0] free_head_q [NUM_AREAS];
	logic [NW-1:0] area_size_q [NUM_AREAS];
	logic [15:0] alloc_run_q [NUM_AREAS];
	logic [ACW-1:0] area_count_q;
	logic [AW-1:0] current_area_q;
	logic hint_valid_q;
	logic [AW-1:0] hint_area_q;
	logic [SW-1:0] hint_slot_q;
	logic [LW-1:0] free_count_q;

	logic [AW-1:0] area_q;
	logic [SW-1:0] slot_q;
	logic [LW-1:0] tap_q;
	logic [LW-1:0] prev_q;
	logic [SW-1:0] nhint_q;
	logic [LW-1:0] steps_q;
	logic from_mem_q;
	logic hit_q;
	logic [SW-1:0] add_addr_q;
	logic [NW-1:0] add_left_q;
	logic [1:0] res_status_q;
	logic [11:0] res_grant_q;
	out_beat_t out_q;
	logic out_valid_q;

	logic ram_we, ram_re;
	logic [SW-1:0] ram_waddr, ram_raddr;
	logic [LW-1:0] ram_wdata, ram_rdata, link_rd;

	logic accept;
	logic out_load;
	logic [11:0] sl_area, sl_off;
	logic [SW-1:0] sl_slot;
	logic slot_ok;
	logic [AW-1:0] ai;
	logic [LW-1:0] head_a;
	logic hint_hit_c;
	logic [XW-1:0] n_x, skip_x, n_sat, skip_sat;
	logic [LW-1:0] add_base;
	logic [LW:0] add_sum;
	logic [ACW-1:0] na_inc;
	logic [AW-1:0] next_a;
	logic [LW-1:0] tap_cur;
	logic walk_cont;
	logic [15:0] run_inc;

	issa_link_ram #(
		.DEPTH (TOTAL),
		.ADDR_W(SW),
		.DATA_W(LW)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready);

	assign link_rd = (ram_rdata > NIL) ? NIL : ram_rdata;
	assign tap_cur = from_mem_q ? link_rd : tap_q;
	assign walk_cont = (tap_cur != NIL) && (tap_cur < LW'(slot_q)) && (steps_q < NIL);

	assign sl_area = 12'(in_data.slot / SLOTS_PER_AREA);
	assign sl_off = 12'(in_data.slot % SLOTS_PER_AREA);
	assign sl_slot = SW'(in_data.slot);
	assign ai = (state_q == S_IDLE) ? AW'(sl_area) : area_q;
	assign head_a = free_head_q[ai];
	assign slot_ok = (sl_area < 12'(area_count_q))
		&& (XW'(sl_off) < XW'(area_size_q[ai]));
	assign hint_hit_c = hint_valid_q && (hint_area_q == ai) && (hint_slot_q < sl_slot);

	assign n_x = XW'(in_data.area_slots);
	assign skip_x = XW'(in_data.skip_slots);
	always_comb begin
		n_sat = (n_x > XW'(SLOTS_PER_AREA)) ? XW'(SLOTS_PER_AREA) : n_x;
		skip_sat = (skip_x > XW'(SLOTS_PER_AREA)) ? XW'(SLOTS_PER_AREA) : skip_x;
		if (n_sat < skip_sat) begin
			n_sat = skip_sat;
		end
	end
	assign add_base = LW'(area_count_q) * LW'(SLOTS_PER_AREA);
	assign add_sum = (LW + 1)'(free_count_q) + (LW + 1)'(n_sat - skip_sat);

	assign na_inc = ACW'(area_q) + ACW'(1);
	assign next_a = (na_inc >= area_count_q) ? '0 : AW'(na_inc);
	assign run_inc = alloc_run_q[area_q] + 16'd1;

	always_comb begin
		ram_we = 1'b0;
		ram_re = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && in_data.action == ACT_FREE && slot_ok) begin
					if (!sorted_free_q) begin
						ram_we = 1'b1;
						ram_waddr = sl_slot;
						ram_wdata = head_a;
					end else if (hint_hit_c) begin
						ram_re = 1'b1;
						ram_raddr = hint_slot_q;
					end
				end
			end
			S_ALLOC: begin
				ram_re = 1'b1;
				ram_raddr = head_a[SW-1:0];
			end
			S_WALK: begin
				if (walk_cont) begin
					ram_re = 1'b1;
					ram_raddr = tap_cur[SW-1:0];
				end else if (tap_cur != LW'(slot_q) && prev_q != NIL) begin
					ram_we = 1'b1;
					ram_waddr = prev_q[SW-1:0];
					ram_wdata = LW'(slot_q);
				end
			end
			S_INS: begin
				ram_we = 1'b1;
				ram_waddr = slot_q;
				ram_wdata = tap_q;
			end
			S_ADD: begin
				ram_we = 1'b1;
				ram_waddr = add_addr_q;
				ram_wdata = (add_left_q > NW'(1)) ? LW'(add_addr_q) + LW'(1) : NIL;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_contig_q <= 16'd256;
			sorted_free_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MAX_CONTIG: max_contig_q <= cfg_wdata;
				CFG_SORTED_FREE: sorted_free_q <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < NUM_AREAS; i++) begin
				free_head_q[i] <= NIL;
				area_size_q[i] <= '0;
				alloc_run_q[i] <= '0;
			end
			area_count_q <= '0;
			current_area_q <= '0;
			hint_valid_q <= 1'b0;
			hint_area_q <= '0;
			hint_slot_q <= '0;
			free_count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_grant_q <= '0;
						hit_q <= (in_data.action == ACT_FREE) && slot_ok
							&& sorted_free_q && hint_hit_c;
						case (in_data.action)
							ACT_ALLOC: begin
								if (area_count_q == '0
										|| ACW'(current_area_q) >= area_count_q) begin
									res_status_q <= ST_NO_FREE;
									state_q <= S_FIN;
								end else begin
									res_status_q <= ST_OK;
									area_q <= current_area_q;
									state_q <= S_ALLOC;
								end
							end
							ACT_FREE: begin
								if (!slot_ok) begin
									res_status_q <= ST_NO_AREA;
									state_q <= S_FIN;
								end else if (!sorted_free_q) begin
									res_status_q <= ST_OK;
									free_head_q[ai] <= LW'(sl_slot);
									if (free_count_q < NIL) begin
										free_count_q <= free_count_q + LW'(1);
									end
									state_q <= S_FIN;
								end else begin
									res_status_q <= ST_OK;
									area_q <= ai;
									slot_q <= sl_slot;
									steps_q <= '0;
									if (hint_hit_c) begin
										prev_q <= LW'(hint_slot_q);
										nhint_q <= hint_slot_q;
										from_mem_q <= 1'b1;
									end else begin
										prev_q <= NIL;
										tap_q <= head_a;
										nhint_q <= sl_slot;
										from_mem_q <= 1'b0;
									end
									state_q <= S_WALK;
								end
							end
							ACT_ADD: begin
								if (area_count_q >= ACW'(NUM_AREAS)) begin
									res_status_q <= ST_TABLE_FULL;
									state_q <= S_FIN;
								end else begin
									res_status_q <= ST_OK;
									area_size_q[AW'(area_count_q)] <= NW'(n_sat);
									alloc_run_q[AW'(area_count_q)] <= '0;
									free_head_q[AW'(area_count_q)] <= (n_sat > skip_sat)
										? add_base + LW'(skip_sat) : NIL;
									free_count_q <= (add_sum > (LW + 1)'(TOTAL))
										? NIL : LW'(add_sum);
									area_count_q <= area_count_q + ACW'(1);
									if (n_sat > skip_sat) begin
										add_addr_q <= SW'(add_base + LW'(skip_sat));
										add_left_q <= NW'(n_sat - skip_sat);
										state_q <= S_ADD;
									end else begin
										state_q <= S_FIN;
									end
								end
							end
							default: begin
								res_status_q <= ST_OK;
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_ALLOC: begin
					if (head_a != NIL) begin
						state_q <= S_POP;
					end else begin
						alloc_run_q[area_q] <= '0;
						area_q <= next_a;
						if (next_a == current_area_q) begin
							res_status_q <= ST_NO_FREE;
							state_q <= S_FIN;
						end
					end
				end
				S_POP: begin
					if (hint_valid_q && hint_area_q == area_q
							&& LW'(hint_slot_q) == head_a) begin
						hint_valid_q <= 1'b0;
					end
					free_head_q[area_q] <= link_rd;
					if (run_inc >= max_contig_q) begin
						alloc_run_q[area_q] <= '0;
						if (area_q == current_area_q) begin
							current_area_q <= next_a;
						end
					end else begin
						alloc_run_q[area_q] <= run_inc;
						current_area_q <= area_q;
					end
					if (free_count_q != '0) begin
						free_count_q <= free_count_q - LW'(1);
					end
					res_grant_q <= 12'(head_a);
					state_q <= S_FIN;
				end
				S_WALK: begin
					from_mem_q <= walk_cont;
					if (walk_cont) begin
						prev_q <= tap_cur;
						nhint_q <= tap_cur[SW-1:0];
						steps_q <= steps_q + LW'(1);
					end else begin
						tap_q <= tap_cur;
						if (tap_cur == LW'(slot_q)) begin
							state_q <= S_FIN;
						end else begin
							if (prev_q == NIL) begin
								free_head_q[area_q] <= LW'(slot_q);
							end
							state_q <= S_INS;
						end
					end
				end
				S_INS: begin
					hint_valid_q <= 1'b1;
					hint_area_q <= area_q;
					hint_slot_q <= nhint_q;
					if (free_count_q < NIL) begin
						free_count_q <= free_count_q + LW'(1);
					end
					state_q <= S_FIN;
				end
				S_ADD: begin
					add_addr_q <= add_addr_q + SW'(1);
					add_left_q <= add_left_q - NW'(1);
					if (add_left_q == NW'(1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						out_q.status <= res_status_q;
						out_q.granted_slot <= res_grant_q;
						out_q.free_total <= 13'(free_count_q);
						out_q.hint_hit <= hit_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, free_count_q <= NIL)
	`ASSERT_IMP(a_areas_bound, clk, arst_n, 1'b1, area_count_q <= ACW'(NUM_AREAS))
	`ASSERT_IMP(a_hint_area, clk, arst_n, hint_valid_q, ACW'(hint_area_q) < area_count_q)
	`ASSERT_IMP(a_cur_area, clk, arst_n, area_count_q != '0,
		ACW'(current_area_q) < area_count_q)
	`ASSERT_NXT(a_fin_out, clk, arst_n, state_q == S_FIN && (!out_valid_q || out_ready),
		out_valid_q && state_q == S_IDLE)
endmodule

@@ sv/issa_link_ram.sv @@
// Link memory: one write port, one registered read port.
module issa_link_ram #(
	parameter int DEPTH = 4096,
	parameter int ADDR_W = 12,
	parameter int DATA_W = 13
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);
	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
